FILE: rtl/cht_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cht_pkg
// Shared sizes, status codes and the bucket-table entry type of the chained
// hash table.
// ----------------------------------------------------------------------------
package cht_pkg;

  localparam int Buckets   = 64;
  localparam int PoolNodes = 128;
  localparam int BktW      = $clog2(Buckets);
  localparam int NodeW     = $clog2(PoolNodes);
  localparam int LinkW     = NodeW + 1;
  localparam int CntW      = 7;
  localparam int KeyW      = 31;
  localparam int OpW       = 2;
  localparam int StW       = 3;
  localparam int BktOutW   = 6;

  localparam logic [LinkW-1:0] NilLink = LinkW'(PoolNodes);

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_SPARE  = 2'd3
  } op_t;

  localparam logic [StW-1:0] ST_INSERTED  = 3'd0;
  localparam logic [StW-1:0] ST_DELETED   = 3'd1;
  localparam logic [StW-1:0] ST_FOUND     = 3'd2;
  localparam logic [StW-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [StW-1:0] ST_POOL_FULL = 3'd4;

  // bucket table entry: used flag and head node
  typedef struct packed {
    logic             used;
    logic [NodeW-1:0] head;
  } bkt_t;

  // node pool entry: key and link
  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [LinkW-1:0] link;
  } node_t;

endpackage : cht_pkg
`default_nettype wire

FILE: rtl/cht_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cht_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module cht_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule : cht_ram
`default_nettype wire

FILE: rtl/cht_mod.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cht_mod
// Restoring remainder of a 31-bit key by a bucket count, one bit per cycle.
// ----------------------------------------------------------------------------
module cht_mod (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [cht_pkg::KeyW-1:0] key,
  input  wire logic [cht_pkg::CntW-1:0] divisor,
  output logic                          done,
  output logic      [cht_pkg::BktW-1:0] rem
);
  import cht_pkg::*;

  localparam int BitW = $clog2(KeyW + 1);

  logic [KeyW-1:0] shf_r, shf_nxt;
  logic [CntW:0]   rem_r, rem_nxt;
  logic [BitW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CntW:0]   trial;

  always_comb begin
    shf_nxt  = shf_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[CntW-1:0], shf_r[KeyW-1]};
    if (start) begin
      shf_nxt  = key;
      rem_nxt  = '0;
      cnt_nxt  = BitW'(KeyW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      shf_nxt = {shf_r[KeyW-2:0], 1'b0};
      rem_nxt = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == BitW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    shf_r <= shf_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r[BktW-1:0];

  as_rem_lt : assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> rem_r < {1'b0, divisor})
    else $error("remainder not below divisor");
  as_no_overlap : assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("done while busy");
  as_busy_cnt : assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0)
    else $error("busy with no bits left");

endmodule : cht_mod
`default_nettype wire

FILE: rtl/chained_hash_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chained_hash_table
// Hash table of 31-bit keys with separate chaining over a fixed node pool.
// ----------------------------------------------------------------------------
// in_tdata  carries op [1:0] and key_value [32:2]; one beat is one request.
// out_tdata carries status [2:0] and bucket_index [8:3]; one beat per request.
// cfg_tdata[6:0] sets the bucket count (1..64; 0 acts as 1, above 64 as 64);
// write it only while the table is idle.
// A request takes the key modulo the bucket count, one quotient bit per cycle,
// then reads the bucket head and walks the chain with one node-pool read per
// node visited.
// Taking a node from the free list adds a read of its link, and unlinking a
// node behind the head adds a pass that reads back and rewrites its
// predecessor.
// One request is in flight at a time; the next beat is taken in the cycle its
// predecessor's result is loaded. in_tready is high while idle, so the next
// beat may enter while the receiver stalls; a finished request then waits
// until out_tready frees the output register.
// Reset empties every chain and the free list at once; no clearing pass.
// ----------------------------------------------------------------------------
module chained_hash_table (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // op, key_value
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // status, bucket_index
  input  wire logic        cfg_tvalid,
  output logic             cfg_tready,
  input  wire logic [7:0]  cfg_tdata   // bucket_count
);
  import cht_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MOD, S_BRD, S_BCHK, S_NRD, S_NCHK, S_DELF, S_OUT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  op_t              op_r, op_nxt;
  logic [KeyW-1:0]  key_r, key_nxt;
  logic [BktW-1:0]  bkt_r, bkt_nxt;
  logic [LinkW-1:0] cur_r, cur_nxt, prev_r, prev_nxt;
  logic [NodeW-1:0] newn_r, newn_nxt;
  logic [LinkW-1:0] free_r, free_nxt;
  logic [LinkW-1:0] fresh_r, fresh_nxt;
  logic [StW-1:0]   st_r, st_nxt;
  logic             ov_r, ov_nxt;
  logic [StW-1:0]   ost_r, ost_nxt;
  logic [BktW-1:0]  obkt_r, obkt_nxt;
  logic [Buckets-1:0] used_r, used_nxt;

  logic             b_we, n_we;
  logic [BktW-1:0]  b_addr;
  logic [NodeW-1:0] n_addr;
  logic [NodeW-1:0] b_wd, b_rd;
  node_t            n_wd, n_rd;
  logic             mod_start, mod_done;
  logic [BktW-1:0]  mod_rem;
  logic [CntW-1:0]  eff_cnt;

  always_comb begin
    eff_cnt = cnt_r;
    if (cnt_r == '0) eff_cnt = CntW'(1);
    if (cnt_r > CntW'(Buckets)) eff_cnt = CntW'(Buckets);
  end

  // the key is loaded into the divider in the accepting cycle
  cht_mod u_mod (
    .clk, .rst_n, .start(mod_start), .key(key_nxt), .divisor(eff_cnt),
    .done(mod_done), .rem(mod_rem)
  );

  cht_ram #(.Width(NodeW), .Depth(Buckets)) u_bkt (
    .clk, .we(b_we), .addr(b_addr), .wdata(b_wd), .rdata(b_rd)
  );

  cht_ram #(.Width(KeyW + LinkW), .Depth(PoolNodes)) u_node (
    .clk, .we(n_we), .addr(n_addr), .wdata(n_wd), .rdata(n_rd)
  );

  assign in_tready  = (state_r == S_IDLE) || ((state_r == S_OUT) && !ov_r);
  assign cfg_tready = 1'b1;
  assign out_tvalid = ov_r;
  assign out_tdata  = {7'd0, obkt_r, ost_r};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    op_nxt    = op_r;
    key_nxt   = key_r;
    bkt_nxt   = bkt_r;
    cur_nxt   = cur_r;
    prev_nxt  = prev_r;
    newn_nxt  = newn_r;
    free_nxt  = free_r;
    fresh_nxt = fresh_r;
    st_nxt    = st_r;
    used_nxt  = used_r;
    ov_nxt    = ov_r;
    ost_nxt   = ost_r;
    obkt_nxt  = obkt_r;
    mod_start = 1'b0;
    b_we      = 1'b0;
    b_addr    = bkt_r;
    b_wd      = newn_r;
    n_we      = 1'b0;
    n_addr    = cur_r[NodeW-1:0];
    n_wd      = '{key: key_r, link: NilLink};

    if (cfg_tvalid) cnt_nxt = cfg_tdata[CntW-1:0];
    if (ov_r && out_tready) ov_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          op_nxt    = op_t'(in_tdata[OpW-1:0]);
          key_nxt   = in_tdata[OpW +: KeyW];
          mod_start = 1'b1;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          bkt_nxt   = mod_rem;
          state_nxt = S_BRD;
        end
      end
      S_BRD: begin
        // bucket head is read now; pick a node for an insert
        prev_nxt = NilLink;
        if (op_r == OP_INSERT) begin
          if (free_r < NilLink) begin
            newn_nxt = free_r[NodeW-1:0];
            cur_nxt  = free_r;
            state_nxt = S_DELF; // fetch free-list link first
          end else if (fresh_r < NilLink) begin
            newn_nxt  = fresh_r[NodeW-1:0];
            fresh_nxt = fresh_r + 1'b1;
            state_nxt = S_BCHK;
          end else begin
            st_nxt    = ST_POOL_FULL;
            state_nxt = S_OUT;
          end
        end else begin
          state_nxt = S_BCHK;
        end
      end
      S_DELF: begin
        // n_rd valid next cycle; wait in BCHK via cur marker
        state_nxt = S_BCHK;
      end
      S_BCHK: begin
        if (op_r == OP_INSERT && cur_r == free_r && free_r < NilLink
            && newn_r == free_r[NodeW-1:0] && prev_r == NilLink) begin
          free_nxt = n_rd.link;
          cur_nxt  = NilLink;
        end
        n_addr = newn_r;
        if (op_r == OP_INSERT) begin
          n_we = 1'b1;
          st_nxt = ST_INSERTED;
          if (!used_r[bkt_r]) begin
            used_nxt[bkt_r] = 1'b1;
            b_we      = 1'b1;
            state_nxt = S_OUT;
          end else begin
            cur_nxt   = {1'b0, b_rd};
            state_nxt = S_NRD;
          end
        end else if (!used_r[bkt_r]) begin
          st_nxt    = ST_NOT_FOUND;
          state_nxt = S_OUT;
        end else begin
          cur_nxt   = {1'b0, b_rd};
          state_nxt = S_NRD;
        end
      end
      S_NRD: begin
        state_nxt = S_NCHK;
      end
      S_NCHK: begin
        if (op_r == OP_INSERT) begin
          if (n_rd.link >= NilLink) begin
            n_we      = 1'b1;
            n_wd      = '{key: n_rd.key, link: {1'b0, newn_r}};
            state_nxt = S_OUT;
          end else begin
            cur_nxt   = n_rd.link;
            state_nxt = S_NRD;
          end
        end else if (n_rd.key == key_r) begin
          if (op_r == OP_DELETE) begin
            st_nxt = ST_DELETED;
            n_we   = 1'b1;
            n_wd   = '{key: n_rd.key, link: free_r};
            free_nxt = cur_r;
            if (prev_r >= NilLink) begin
              if (n_rd.link >= NilLink) used_nxt[bkt_r] = 1'b0;
              else begin
                b_we = 1'b1;
                b_wd = n_rd.link[NodeW-1:0];
              end
              state_nxt = S_OUT;
            end else begin
              // relink predecessor: we still need its key, read it back
              newn_nxt  = n_rd.link[NodeW-1:0];
              cur_nxt   = prev_r;
              prev_nxt  = n_rd.link;
              op_nxt    = OP_SPARE;
              state_nxt = S_NRD;
            end
          end else begin
            st_nxt    = ST_FOUND;
            state_nxt = S_OUT;
          end
        end else if (n_rd.link >= NilLink) begin
          st_nxt    = ST_NOT_FOUND;
          state_nxt = S_OUT;
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = n_rd.link;
          state_nxt = S_NRD;
        end
        if (op_r == OP_SPARE && st_r == ST_DELETED) begin
          // predecessor rewrite pass of a delete
          n_we      = 1'b1;
          n_wd      = '{key: n_rd.key, link: prev_r};
          free_nxt  = free_r;
          used_nxt  = used_r;
          b_we      = 1'b0;
          st_nxt    = ST_DELETED;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_r) begin
          ov_nxt   = 1'b1;
          ost_nxt  = st_r;
          obkt_nxt = bkt_r[BktOutW-1:0];
          state_nxt = S_IDLE;
          if (in_tvalid) begin
            op_nxt    = op_t'(in_tdata[OpW-1:0]);
            key_nxt   = in_tdata[OpW +: KeyW];
            mod_start = 1'b1;
            st_nxt    = ST_NOT_FOUND;
            state_nxt = S_MOD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_OUT || state_r == S_IDLE) begin
      if (op_nxt == OP_SPARE && mod_start) st_nxt = ST_NOT_FOUND;
    end
    if (state_r != S_NCHK && state_r != S_DELF && state_r != S_BRD) begin
      if (state_r == S_IDLE || state_r == S_OUT) prev_nxt = NilLink;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= CntW'(Buckets);
      used_r  <= '0;
      free_r  <= NilLink;
      fresh_r <= '0;
      ov_r    <= 1'b0;
      st_r    <= ST_NOT_FOUND;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      used_r  <= used_nxt;
      free_r  <= free_nxt;
      fresh_r <= fresh_nxt;
      ov_r    <= ov_nxt;
      st_r    <= st_nxt;
    end
    op_r   <= op_nxt;
    key_r  <= key_nxt;
    bkt_r  <= bkt_nxt;
    cur_r  <= cur_nxt;
    prev_r <= prev_nxt;
    newn_r <= newn_nxt;
    ost_r  <= ost_nxt;
    obkt_r <= obkt_nxt;
  end

  as_fresh_max : assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r <= NilLink) else $error("fresh count past pool");
  as_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_tready |=> ov_r && $stable(ost_r)) else $error("result lost");
  as_status_range : assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> ost_r <= ST_POOL_FULL) else $error("bad status");

endmodule : chained_hash_table
`default_nettype wire
